>>> hw/rtl/poly1305_two_stream_mac_core_assert.svh
// Assertion macros shared by the Poly1305 two-stream MAC core.
`ifndef POLY1305_TWO_STREAM_MAC_CORE_ASSERT_SVH
`define POLY1305_TWO_STREAM_MAC_CORE_ASSERT_SVH

// Checks that cond holds whenever trig holds, in the same cycle.
`define P1305_ASSERT_IMPL(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Checks that cond holds in the cycle after trig.
`define P1305_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

>>> hw/rtl/p1305_pkg.sv
// Shared types, codes and tables of the Poly1305 two-stream MAC core.
`timescale 1ns / 1ps
package p1305_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_AAD   = 2'd1,
        OP_MSG   = 2'd2,
        OP_FINAL = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        JOB_CLEAR = 2'd0,
        JOB_BLOCK = 2'd1,
        JOB_LAST  = 2'd2
    } job_kind_t;

    typedef struct packed {
        job_kind_t    kind;
        logic         hibit;
        logic [127:0] data;
    } job_t;

    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_R_LOW         = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_R_HIGH        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PAD_LOW       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PAD_HIGH      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_LOW  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_HIGH = 3'd5;

    localparam logic [31:0] CLAMP_R0 = 32'h0fffffff;
    localparam logic [31:0] CLAMP_RN = 32'h0ffffffc;

    // Multiplier operand codes: r words, then the 5/4-scaled words.
    localparam logic [2:0] RSEL_R0 = 3'd0;
    localparam logic [2:0] RSEL_R1 = 3'd1;
    localparam logic [2:0] RSEL_R2 = 3'd2;
    localparam logic [2:0] RSEL_R3 = 3'd3;
    localparam logic [2:0] RSEL_S1 = 3'd4;
    localparam logic [2:0] RSEL_S2 = 3'd5;
    localparam logic [2:0] RSEL_S3 = 3'd6;

    localparam int NUM_PRODUCTS = 20;
    localparam int STEP_W       = 5;

    typedef struct packed {
        logic [2:0] hsel;
        logic [2:0] rsel;
        logic [2:0] dsel;
    } mul_step_t;

    // Schedule of the partial products: accumulator word, r operand, target sum.
    function automatic mul_step_t mul_step(input logic [STEP_W-1:0] k);
        mul_step_t s;
        s = '0;
        case (k)
            5'd0:    s = '{3'd0, RSEL_R0, 3'd0};
            5'd1:    s = '{3'd1, RSEL_S3, 3'd0};
            5'd2:    s = '{3'd2, RSEL_S2, 3'd0};
            5'd3:    s = '{3'd3, RSEL_S1, 3'd0};
            5'd4:    s = '{3'd0, RSEL_R1, 3'd1};
            5'd5:    s = '{3'd1, RSEL_R0, 3'd1};
            5'd6:    s = '{3'd2, RSEL_S3, 3'd1};
            5'd7:    s = '{3'd3, RSEL_S2, 3'd1};
            5'd8:    s = '{3'd4, RSEL_S1, 3'd1};
            5'd9:    s = '{3'd0, RSEL_R2, 3'd2};
            5'd10:   s = '{3'd1, RSEL_R1, 3'd2};
            5'd11:   s = '{3'd2, RSEL_R0, 3'd2};
            5'd12:   s = '{3'd3, RSEL_S3, 3'd2};
            5'd13:   s = '{3'd4, RSEL_S2, 3'd2};
            5'd14:   s = '{3'd0, RSEL_R3, 3'd3};
            5'd15:   s = '{3'd1, RSEL_R2, 3'd3};
            5'd16:   s = '{3'd2, RSEL_R1, 3'd3};
            5'd17:   s = '{3'd3, RSEL_R0, 3'd3};
            5'd18:   s = '{3'd4, RSEL_S3, 3'd3};
            5'd19:   s = '{3'd4, RSEL_R0, 3'd4};
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

>>> hw/rtl/poly1305_two_stream_mac_core.sv
// Block engine: each 16-byte block is absorbed with one 32x32 multiplier (20 products), then carry and reduce.
// Throughput: one byte per cycle while the job queue has room and no finalize is in progress.
// Finalize: up to three blocks (two padded, one length), then the FIN1 and FIN2 steps to the tag.
// Reset: asynchronous, active low; clears accumulator, counts, fills, done flag and registers.
// Gather buffers hold no reset value; only bytes below the fill level are ever used.
`timescale 1ns / 1ps
`include "poly1305_two_stream_mac_core_assert.svh"
module poly1305_two_stream_mac_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         operation,
    input  logic [7:0]                         data_byte,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [63:0]                        tag_low,
    output logic [63:0]                        tag_high,
    output logic                               tag_mismatch,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [p1305_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [63:0]                        cfg_data
);

    logic [63:0]      r_low_reg, r_high_reg, pad_low_reg, pad_high_reg;
    logic [63:0]      expected_low_reg, expected_high_reg;
    logic             q_push, q_full, q_pop, q_not_empty, front_done;
    p1305_pkg::job_t  q_job, q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            r_low_reg         <= '0;
            r_high_reg        <= '0;
            pad_low_reg       <= '0;
            pad_high_reg      <= '0;
            expected_low_reg  <= '0;
            expected_high_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                p1305_pkg::REG_R_LOW:         r_low_reg         <= cfg_data;
                p1305_pkg::REG_R_HIGH:        r_high_reg        <= cfg_data;
                p1305_pkg::REG_PAD_LOW:       pad_low_reg       <= cfg_data;
                p1305_pkg::REG_PAD_HIGH:      pad_high_reg      <= cfg_data;
                p1305_pkg::REG_EXPECTED_LOW:  expected_low_reg  <= cfg_data;
                p1305_pkg::REG_EXPECTED_HIGH: expected_high_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    p1305_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .data_byte (data_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_job),
        .done      (front_done)
    );

    p1305_jobq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_jobq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (q_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    p1305_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_not_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .r_low         (r_low_reg),
        .r_high        (r_high_reg),
        .pad_low       (pad_low_reg),
        .pad_high      (pad_high_reg),
        .expected_low  (expected_low_reg),
        .expected_high (expected_high_reg),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .tag_low       (tag_low),
        .tag_high      (tag_high),
        .tag_mismatch  (tag_mismatch)
    );

    // The front end never queues a job into a full queue.
    `P1305_ASSERT_IMPL(a_no_push_full, q_push, !q_full, "job pushed into full queue")
    // The block engine only takes a job that is there.
    `P1305_ASSERT_IMPL(a_no_pop_empty, q_pop, q_not_empty, "job popped from empty queue")
    // A finalize that takes effect sets the done flag in the next cycle.
    `P1305_ASSERT_NEXT(a_final_sets_done,
        in_valid && !in_stall && operation == p1305_pkg::OP_FINAL,
        front_done, "finalize did not set done flag")

endmodule

>>> hw/rtl/p1305_front.sv
// Front end: takes items, gathers bytes into blocks and queues clear, block and length jobs.
`timescale 1ns / 1ps
module p1305_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        operation,
    input  logic [7:0]        data_byte,
    input  logic              q_full,
    output logic              q_push,
    output p1305_pkg::job_t   q_job,
    output logic              done
);

    typedef enum logic [3:0] {
        F_IDLE    = 4'b0001,
        F_PAD_AAD = 4'b0010,
        F_PAD_MSG = 4'b0100,
        F_LEN     = 4'b1000
    } fstate_t;

    fstate_t      state_reg, state_next;
    logic [7:0]   aad_buf_reg [16];
    logic [7:0]   msg_buf_reg [16];
    logic [3:0]   aad_fill_reg, aad_fill_next;
    logic [3:0]   msg_fill_reg, msg_fill_next;
    logic [63:0]  aad_count_reg, aad_count_next;
    logic [63:0]  msg_count_reg, msg_count_next;
    logic         done_reg, done_next;
    logic         accept;
    p1305_pkg::op_t op;

    // A partial block padded with one 0x01 byte and then zeros.
    function automatic logic [127:0] pad_block(input logic [7:0] b [16], input logic [3:0] fill);
        logic [127:0] v;
        v = '0;
        for (int i = 0; i < 16; i++) begin
            if (4'(i) < fill)
                v[8*i +: 8] = b[i];
            else if (4'(i) == fill)
                v[8*i +: 8] = 8'h01;
        end
        return v;
    endfunction

    function automatic logic [127:0] full_block(input logic [7:0] b [16], input logic [7:0] last);
        logic [127:0] v;
        v = '0;
        for (int i = 0; i < 15; i++)
            v[8*i +: 8] = b[i];
        v[127:120] = last;
        return v;
    endfunction

    assign op       = p1305_pkg::op_t'(operation);
    assign in_stall = (state_reg != F_IDLE) || q_full;
    assign accept   = in_valid && !in_stall;
    assign done     = done_reg;

    always_comb
    begin
        state_next     = state_reg;
        aad_fill_next  = aad_fill_reg;
        msg_fill_next  = msg_fill_reg;
        aad_count_next = aad_count_reg;
        msg_count_next = msg_count_reg;
        done_next      = done_reg;
        q_push         = 1'b0;
        q_job          = '0;
        case (state_reg)
            F_IDLE:
            begin
                if (accept) begin
                    if (op == p1305_pkg::OP_CLEAR) begin
                        aad_fill_next  = '0;
                        msg_fill_next  = '0;
                        aad_count_next = '0;
                        msg_count_next = '0;
                        done_next      = 1'b0;
                        q_push         = 1'b1;
                        q_job.kind     = p1305_pkg::JOB_CLEAR;
                    end else if (!done_reg) begin
                        case (op)
                            p1305_pkg::OP_AAD:
                            begin
                                aad_count_next = aad_count_reg + 64'd1;
                                aad_fill_next  = aad_fill_reg + 4'd1;
                                if (aad_fill_reg == 4'd15) begin
                                    q_push     = 1'b1;
                                    q_job.kind = p1305_pkg::JOB_BLOCK;
                                    q_job.hibit = 1'b1;
                                    q_job.data = full_block(aad_buf_reg, data_byte);
                                end
                            end
                            p1305_pkg::OP_MSG:
                            begin
                                msg_count_next = msg_count_reg + 64'd1;
                                msg_fill_next  = msg_fill_reg + 4'd1;
                                if (msg_fill_reg == 4'd15) begin
                                    q_push     = 1'b1;
                                    q_job.kind = p1305_pkg::JOB_BLOCK;
                                    q_job.hibit = 1'b1;
                                    q_job.data = full_block(msg_buf_reg, data_byte);
                                end
                            end
                            p1305_pkg::OP_FINAL:
                            begin
                                done_next  = 1'b1;
                                state_next = F_PAD_AAD;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            F_PAD_AAD:
            begin
                if (aad_fill_reg == 4'd0) begin
                    state_next = F_PAD_MSG;
                end else if (!q_full) begin
                    q_push     = 1'b1;
                    q_job.kind = p1305_pkg::JOB_BLOCK;
                    q_job.data = pad_block(aad_buf_reg, aad_fill_reg);
                    state_next = F_PAD_MSG;
                end
            end
            F_PAD_MSG:
            begin
                if (msg_fill_reg == 4'd0) begin
                    state_next = F_LEN;
                end else if (!q_full) begin
                    q_push     = 1'b1;
                    q_job.kind = p1305_pkg::JOB_BLOCK;
                    q_job.data = pad_block(msg_buf_reg, msg_fill_reg);
                    state_next = F_LEN;
                end
            end
            F_LEN:
            begin
                if (!q_full) begin
                    q_push      = 1'b1;
                    q_job.kind  = p1305_pkg::JOB_LAST;
                    q_job.hibit = 1'b1;
                    q_job.data  = {msg_count_reg, aad_count_reg};
                    state_next  = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept && !done_reg && op == p1305_pkg::OP_AAD)
            aad_buf_reg[aad_fill_reg] <= data_byte;
        if (accept && !done_reg && op == p1305_pkg::OP_MSG)
            msg_buf_reg[msg_fill_reg] <= data_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= F_IDLE;
            aad_fill_reg  <= '0;
            msg_fill_reg  <= '0;
            aad_count_reg <= '0;
            msg_count_reg <= '0;
            done_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            aad_fill_reg  <= aad_fill_next;
            msg_fill_reg  <= msg_fill_next;
            aad_count_reg <= aad_count_next;
            msg_count_reg <= msg_count_next;
            done_reg      <= done_next;
        end
    end

endmodule

>>> hw/rtl/p1305_jobq.sv
// Small job queue between the front end and the block engine.
`timescale 1ns / 1ps
module p1305_jobq #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  p1305_pkg::job_t   push_job,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output p1305_pkg::job_t   head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    p1305_pkg::job_t     slot_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

>>> hw/rtl/p1305_back.sv
// Block engine: absorbs blocks with one shared multiplier and produces the tag.
`timescale 1ns / 1ps
module p1305_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  p1305_pkg::job_t   q_head,
    output logic              q_pop,
    input  logic [63:0]       r_low,
    input  logic [63:0]       r_high,
    input  logic [63:0]       pad_low,
    input  logic [63:0]       pad_high,
    input  logic [63:0]       expected_low,
    input  logic [63:0]       expected_high,
    input  logic              out_stall,
    output logic              out_valid,
    output logic [63:0]       tag_low,
    output logic [63:0]       tag_high,
    output logic              tag_mismatch
);

    typedef enum logic [5:0] {
        B_IDLE   = 6'b000001,
        B_MUL    = 6'b000010,
        B_CARRY  = 6'b000100,
        B_REDUCE = 6'b001000,
        B_FIN1   = 6'b010000,
        B_FIN2   = 6'b100000
    } bstate_t;

    bstate_t                        state_reg;
    logic [31:0]                    acc_reg [5];
    logic [31:0]                    h_reg [5];
    logic [63:0]                    d_reg [5];
    logic [63:0]                    prod_reg;
    logic [2:0]                     tgt_reg;
    logic [p1305_pkg::STEP_W-1:0]   k_reg;
    logic [1:0]                     j_reg;
    logic                           last_reg;
    logic [127:0]                   hsel_reg;
    logic                           out_valid_reg;
    logic [63:0]                    tag_low_reg, tag_high_reg;
    logic                           mismatch_reg;

    logic [31:0]        r0, r1, r2, r3, s1, s2, s3;
    p1305_pkg::mul_step_t step;
    logic [31:0]        opa, opb;
    logic [128:0]       in_sum;
    logic [31:0]        in_top;
    logic [31:0]        h4v;
    logic [32:0]        c;
    logic [128:0]       red_sum;
    logic [128:0]       g;
    logic [31:0]        g_top;
    logic [127:0]       tag;
    logic [2:0]         j_next_idx;

    assign r0 = r_low[31:0]   & p1305_pkg::CLAMP_R0;
    assign r1 = r_low[63:32]  & p1305_pkg::CLAMP_RN;
    assign r2 = r_high[31:0]  & p1305_pkg::CLAMP_RN;
    assign r3 = r_high[63:32] & p1305_pkg::CLAMP_RN;
    assign s1 = r1 + (r1 >> 2);
    assign s2 = r2 + (r2 >> 2);
    assign s3 = r3 + (r3 >> 2);

    assign step = p1305_pkg::mul_step(k_reg);
    assign opa  = h_reg[step.hsel];

    always_comb
    begin
        case (step.rsel)
            p1305_pkg::RSEL_R0: opb = r0;
            p1305_pkg::RSEL_R1: opb = r1;
            p1305_pkg::RSEL_R2: opb = r2;
            p1305_pkg::RSEL_R3: opb = r3;
            p1305_pkg::RSEL_S1: opb = s1;
            p1305_pkg::RSEL_S2: opb = s2;
            p1305_pkg::RSEL_S3: opb = s3;
            default:            opb = '0;
        endcase
    end

    // Block plus accumulator, with the high bit folded into the top word.
    assign in_sum = {1'b0, acc_reg[3], acc_reg[2], acc_reg[1], acc_reg[0]}
                  + {1'b0, q_head.data};
    assign in_top = acc_reg[4] + 32'(in_sum[128]) + 32'(q_head.hibit);

    // Fold bits above 2^130 back in as times five.
    assign h4v     = d_reg[4][31:0] + d_reg[3][63:32];
    assign c       = 33'(h4v >> 2) + 33'(h4v & ~32'd3);
    assign red_sum = {1'b0, d_reg[3][31:0], d_reg[2][31:0], d_reg[1][31:0], d_reg[0][31:0]}
                   + 129'(c);

    assign g     = {1'b0, acc_reg[3], acc_reg[2], acc_reg[1], acc_reg[0]} + 129'd5;
    assign g_top = acc_reg[4] + 32'(g[128]);
    assign tag   = hsel_reg + {pad_high, pad_low};

    assign j_next_idx = 3'(j_reg) + 3'd1;
    assign q_pop      = (state_reg == B_IDLE) && q_valid;

    assign out_valid    = out_valid_reg;
    assign tag_low      = tag_low_reg;
    assign tag_high     = tag_high_reg;
    assign tag_mismatch = mismatch_reg;

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                h_reg[0] <= in_sum[31:0];
                h_reg[1] <= in_sum[63:32];
                h_reg[2] <= in_sum[95:64];
                h_reg[3] <= in_sum[127:96];
                h_reg[4] <= in_top;
                for (int i = 0; i < 5; i++)
                    d_reg[i] <= '0;
                last_reg <= (q_head.kind == p1305_pkg::JOB_LAST);
            end
            B_MUL:
            begin
                if (k_reg != p1305_pkg::STEP_W'(p1305_pkg::NUM_PRODUCTS)) begin
                    prod_reg <= 64'(opa) * 64'(opb);
                    tgt_reg  <= step.dsel;
                end
                if (k_reg != '0)
                    d_reg[tgt_reg] <= d_reg[tgt_reg] + prod_reg;
            end
            B_CARRY:
            begin
                d_reg[j_next_idx] <= d_reg[j_next_idx] + (d_reg[j_reg] >> 32);
            end
            B_FIN1:
            begin
                hsel_reg <= (g_top[31:2] != '0)
                          ? g[127:0]
                          : {acc_reg[3], acc_reg[2], acc_reg[1], acc_reg[0]};
            end
            B_FIN2:
            begin
                if (!out_valid_reg) begin
                    tag_low_reg  <= tag[63:0];
                    tag_high_reg <= tag[127:64];
                    mismatch_reg <= (tag[63:0] != expected_low)
                                 || (tag[127:64] != expected_high);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= B_IDLE;
            k_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 5; i++)
                acc_reg[i] <= '0;
        end else begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                B_IDLE:
                begin
                    k_reg <= '0;
                    j_reg <= '0;
                    if (q_valid) begin
                        if (q_head.kind == p1305_pkg::JOB_CLEAR) begin
                            for (int i = 0; i < 5; i++)
                                acc_reg[i] <= '0;
                        end else begin
                            state_reg <= B_MUL;
                        end
                    end
                end
                B_MUL:
                begin
                    k_reg <= k_reg + p1305_pkg::STEP_W'(1);
                    if (k_reg == p1305_pkg::STEP_W'(p1305_pkg::NUM_PRODUCTS))
                        state_reg <= B_CARRY;
                end
                B_CARRY:
                begin
                    j_reg <= j_reg + 2'd1;
                    if (j_reg == 2'd2)
                        state_reg <= B_REDUCE;
                end
                B_REDUCE:
                begin
                    acc_reg[0] <= red_sum[31:0];
                    acc_reg[1] <= red_sum[63:32];
                    acc_reg[2] <= red_sum[95:64];
                    acc_reg[3] <= red_sum[127:96];
                    acc_reg[4] <= 32'(h4v[1:0]) + 32'(red_sum[128]);
                    state_reg  <= last_reg ? B_FIN1 : B_IDLE;
                end
                B_FIN1:
                begin
                    state_reg <= B_FIN2;
                end
                B_FIN2:
                begin
                    if (!out_valid_reg) begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

>>> dv/tb_poly1305_two_stream_mac_core.sv
// Self-checking testbench of the two-stream Poly1305 MAC core.
`timescale 1ns / 1ps
module tb_poly1305_two_stream_mac_core;

    typedef struct packed {
        p1305_pkg::op_t op;
        logic [7:0]     data;
    } mac_item_t;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
        logic        mism;
    } tag_item_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic out_valid;
    logic out_stall;
    logic [63:0] tag_low;
    logic [63:0] tag_high;
    logic tag_mismatch;
    logic cfg_valid;
    logic cfg_ready;
    logic [p1305_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [63:0] cfg_data;

    poly1305_two_stream_mac_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .data_byte(data_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .tag_low(tag_low), .tag_high(tag_high), .tag_mismatch(tag_mismatch),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Predictor state.
    logic [63:0] key_reg [0:5];
    logic [31:0] acc [0:4];
    logic [7:0]  aad_buf [0:15];
    logic [7:0]  msg_buf [0:15];
    int unsigned aad_fill;
    int unsigned msg_fill;
    logic [63:0] aad_len;
    logic [63:0] msg_len;
    logic        sealed;
    tag_item_t   last_tag;

    mac_item_t pending_items [$];
    tag_item_t expected_tags [$];
    int        mismatch_count;
    int        tags_seen;
    int        finals_sent;
    bit        driver_busy;
    int        burst_left;
    int        gap_left;
    int        stall_phase;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    function automatic void absorb_block(input logic [127:0] blk, input logic [31:0] hibit);
        logic [63:0] r0, r1, r2, r3, s1, s2, s3, h0, h1, h2, h3, h4, t, d0, d1, d2, d3, c;
        r0 = key_reg[p1305_pkg::REG_R_LOW][31:0] & p1305_pkg::CLAMP_R0;
        r1 = key_reg[p1305_pkg::REG_R_LOW][63:32] & p1305_pkg::CLAMP_RN;
        r2 = key_reg[p1305_pkg::REG_R_HIGH][31:0] & p1305_pkg::CLAMP_RN;
        r3 = key_reg[p1305_pkg::REG_R_HIGH][63:32] & p1305_pkg::CLAMP_RN;
        s1 = r1 + (r1 >> 2);
        s2 = r2 + (r2 >> 2);
        s3 = r3 + (r3 >> 2);
        t = acc[0] + blk[31:0];              h0 = t[31:0];
        t = acc[1] + (t >> 32) + blk[63:32]; h1 = t[31:0];
        t = acc[2] + (t >> 32) + blk[95:64]; h2 = t[31:0];
        t = acc[3] + (t >> 32) + blk[127:96]; h3 = t[31:0];
        h4 = (acc[4] + (t >> 32) + hibit) & 64'hffffffff;
        d0 = h0 * r0 + h1 * s3 + h2 * s2 + h3 * s1;
        d1 = h0 * r1 + h1 * r0 + h2 * s3 + h3 * s2 + h4 * s1;
        d2 = h0 * r2 + h1 * r1 + h2 * r0 + h3 * s3 + h4 * s2;
        d3 = h0 * r3 + h1 * r2 + h2 * r1 + h3 * r0 + h4 * s3;
        h4 = (h4 * r0) & 64'hffffffff;
        h0 = d0 & 64'hffffffff;
        d1 += d0 >> 32; h1 = d1 & 64'hffffffff;
        d2 += d1 >> 32; h2 = d2 & 64'hffffffff;
        d3 += d2 >> 32; h3 = d3 & 64'hffffffff;
        h4 = (h4 + (d3 >> 32)) & 64'hffffffff;
        c = (h4 >> 2) + (h4 & ~64'd3);
        h4 &= 3;
        t = h0 + c;         acc[0] = t[31:0];
        t = h1 + (t >> 32); acc[1] = t[31:0];
        t = h2 + (t >> 32); acc[2] = t[31:0];
        t = h3 + (t >> 32); acc[3] = t[31:0];
        t = h4 + (t >> 32); acc[4] = t[31:0];
    endfunction

    function automatic logic [127:0] pack_bytes(input logic [7:0] b [0:15], input int fill);
        logic [127:0] blk;
        blk = '0;
        for (int i = 0; i < 16; i++)
            if (i < fill)
                blk[8*i +: 8] = b[i];
        if (fill < 16)
            blk[8*fill +: 8] = 8'h01;
        return blk;
    endfunction

    function automatic void clear_mac_state();
        for (int i = 0; i < 5; i++)
            acc[i] = '0;
        aad_fill = 0;
        msg_fill = 0;
        aad_len = '0;
        msg_len = '0;
        sealed = 1'b0;
    endfunction

    // Updates the predicted state for one accepted item and queues any tag.
    function automatic void predict_tag(input mac_item_t it);
        logic [31:0] h [0:4];
        logic [31:0] g [0:3];
        logic [63:0] t;
        logic [127:0] lens;
        tag_item_t res;
        if (it.op == p1305_pkg::OP_CLEAR)
        begin
            clear_mac_state();
            return;
        end
        if (sealed)
            return;
        if (it.op == p1305_pkg::OP_AAD)
        begin
            aad_buf[aad_fill] = it.data;
            aad_len++;
            aad_fill++;
            if (aad_fill == 16)
            begin
                absorb_block(pack_bytes(aad_buf, 16), 1);
                aad_fill = 0;
            end
            return;
        end
        if (it.op == p1305_pkg::OP_MSG)
        begin
            msg_buf[msg_fill] = it.data;
            msg_len++;
            msg_fill++;
            if (msg_fill == 16)
            begin
                absorb_block(pack_bytes(msg_buf, 16), 1);
                msg_fill = 0;
            end
            return;
        end
        sealed = 1'b1;
        if (aad_fill != 0)
            absorb_block(pack_bytes(aad_buf, aad_fill), 0);
        if (msg_fill != 0)
            absorb_block(pack_bytes(msg_buf, msg_fill), 0);
        lens = {msg_len, aad_len};
        absorb_block(lens, 1);
        for (int i = 0; i < 5; i++)
            h[i] = acc[i];
        t = h[0] + 64'd5;       g[0] = t[31:0];
        t = h[1] + (t >> 32);   g[1] = t[31:0];
        t = h[2] + (t >> 32);   g[2] = t[31:0];
        t = h[3] + (t >> 32);   g[3] = t[31:0];
        if (((h[4] + t[63:32]) >> 2) != 0)
            for (int i = 0; i < 4; i++)
                h[i] = g[i];
        t = h[0] + key_reg[p1305_pkg::REG_PAD_LOW][31:0];               h[0] = t[31:0];
        t = h[1] + (t >> 32) + key_reg[p1305_pkg::REG_PAD_LOW][63:32];  h[1] = t[31:0];
        t = h[2] + (t >> 32) + key_reg[p1305_pkg::REG_PAD_HIGH][31:0];  h[2] = t[31:0];
        t = h[3] + (t >> 32) + key_reg[p1305_pkg::REG_PAD_HIGH][63:32]; h[3] = t[31:0];
        res.lo = {h[1], h[0]};
        res.hi = {h[3], h[2]};
        res.mism = (res.lo != key_reg[p1305_pkg::REG_EXPECTED_LOW])
                || (res.hi != key_reg[p1305_pkg::REG_EXPECTED_HIGH]);
        last_tag = res;
        expected_tags.push_back(res);
    endfunction

    // Driver: bursts with random gaps.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_tag(mac_item_t'({operation, data_byte}));
                if (operation == p1305_pkg::OP_FINAL)
                    finals_sent++;
            end
            if (in_valid && in_stall)
            begin
                // Hold the stalled item.
            end
            else if (pending_items.size() != 0 && gap_left == 0)
            begin
                mac_item_t it;
                it = pending_items.pop_front();
                in_valid <= 1'b1;
                operation <= it.op;
                data_byte <= it.data;
                driver_busy = 1'b1;
                if (burst_left == 0)
                    burst_left = $urandom_range(1, 40);
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end
            else
            begin
                in_valid <= 1'b0;
                operation <= $urandom_range(0, 3);
                data_byte <= $urandom_range(0, 255);
                driver_busy = (pending_items.size() != 0);
                if (gap_left != 0)
                    gap_left--;
            end
        end
    end

    // Monitor and receiver stall pattern.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                tags_seen++;
                if (expected_tags.size() == 0)
                begin
                    report_mismatch("unexpected tag_low", tag_low, 64'd0);
                end
                else
                begin
                    tag_item_t w;
                    w = expected_tags.pop_front();
                    if (tag_low !== w.lo)
                        report_mismatch("tag_low", tag_low, w.lo);
                    if (tag_high !== w.hi)
                        report_mismatch("tag_high", tag_high, w.hi);
                    if (tag_mismatch !== w.mism)
                        report_mismatch("tag_mismatch", 64'(tag_mismatch), 64'(w.mism));
                end
            end
            stall_phase = (stall_phase + 1) % 64;
            if (stall_phase < 24)
                out_stall <= 1'b0;
            else if (stall_phase < 40)
                out_stall <= ($urandom_range(0, 1) == 0);
            else
                out_stall <= ($urandom_range(0, 7) == 0);
        end
    end

    task automatic write_reg(input logic [p1305_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [63:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        key_reg[idx] = value;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] pick_value(input int mode);
        case (mode)
            0: return '0;
            1: return '1;
            default: return rand64();
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || driver_busy || in_valid || expected_tags.size() != 0)
            @(posedge clk);
        // A finalize still in the engine may be followed by cleared work; let it settle.
        repeat (120)
            @(posedge clk);
    endtask

    task automatic push_item(input p1305_pkg::op_t op, input logic [7:0] b);
        mac_item_t it;
        it.op = op;
        it.data = b;
        pending_items.push_back(it);
    endtask

    // One random message: mostly well-formed clear, data, finalize sequences.
    task automatic push_random_message(input int max_len);
        int na;
        int nm;
        na = $urandom_range(0, max_len);
        nm = $urandom_range(0, max_len);
        push_item(p1305_pkg::OP_CLEAR, $urandom_range(0, 255));
        for (int i = 0; i < na + nm; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                push_item(p1305_pkg::op_t'($urandom_range(0, 3)), $urandom_range(0, 255));
            else if (i < na)
                push_item(p1305_pkg::OP_AAD, $urandom_range(0, 255));
            else
                push_item(p1305_pkg::OP_MSG, $urandom_range(0, 255));
        end
        push_item(p1305_pkg::OP_FINAL, $urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0)
            push_item(p1305_pkg::op_t'($urandom_range(1, 3)), $urandom_range(0, 255));
    endtask

    initial
    begin
        int item_total;
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = p1305_pkg::OP_CLEAR;
        data_byte = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = p1305_pkg::REG_R_LOW;
        cfg_data = '0;
        mismatch_count = 0;
        tags_seen = 0;
        finals_sent = 0;
        driver_busy = 1'b0;
        burst_left = 0;
        gap_left = 0;
        stall_phase = 0;
        last_tag = '0;
        for (int i = 0; i < 6; i++)
            key_reg[i] = '0;
        for (int i = 0; i < 16; i++)
        begin
            aad_buf[i] = '0;
            msg_buf[i] = '0;
        end
        clear_mac_state();
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero key first, then all-ones key with partial blocks and ignored items.
        push_item(p1305_pkg::OP_FINAL, 8'h00);
        wait_drained();
        for (int i = 0; i < 6; i++)
            write_reg(i[p1305_pkg::CFG_INDEX_W-1:0], '1);
        push_item(p1305_pkg::OP_CLEAR, 8'hff);
        for (int i = 0; i < 17; i++)
            push_item(p1305_pkg::OP_AAD, (i % 2) ? 8'hff : 8'h00);
        push_item(p1305_pkg::OP_MSG, 8'hff);
        push_item(p1305_pkg::OP_MSG, 8'h00);
        push_item(p1305_pkg::OP_FINAL, 8'h00);
        push_item(p1305_pkg::OP_AAD, 8'h55);
        push_item(p1305_pkg::OP_MSG, 8'haa);
        push_item(p1305_pkg::OP_FINAL, 8'hff);
        wait_drained();

        // Random phases, each with a fresh key setting.
        item_total = 0;
        for (int ph = 0; ph < 8; ph++)
        begin
            for (int i = 0; i < 6; i++)
                write_reg(i[p1305_pkg::CFG_INDEX_W-1:0], pick_value(ph < 2 ? ph : 2));
            for (int m = 0; m < 4; m++)
            begin
                if (ph == 3 && m == 0)
                begin
                    push_random_message(20);
                    item_total += pending_items.size();
                    wait_drained();
                    write_reg(p1305_pkg::REG_EXPECTED_LOW, {$urandom(), $urandom()});
                end
                push_random_message(m == 3 ? 40 : 20);
            end
            item_total += pending_items.size();
            wait_drained();
            if (item_total > 500)
                break;
        end

        // Matching tag: compute the tag under a fixed key, load it as expected, then repeat.
        push_item(p1305_pkg::OP_CLEAR, 8'h00);
        push_item(p1305_pkg::OP_MSG, 8'h42);
        push_item(p1305_pkg::OP_FINAL, 8'h00);
        wait_drained();
        write_reg(p1305_pkg::REG_EXPECTED_LOW, last_tag.lo);
        write_reg(p1305_pkg::REG_EXPECTED_HIGH, last_tag.hi);
        push_item(p1305_pkg::OP_CLEAR, 8'h00);
        push_item(p1305_pkg::OP_MSG, 8'h42);
        push_item(p1305_pkg::OP_FINAL, 8'h00);
        wait_drained();

        $display("Covered %0d finalize items and %0d checked tags over several key settings.",
                 finals_sent, tags_seen);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Timeout at %0t", $realtime);
        $display("Mismatches found");
        $finish;
    end
endmodule
